// ===== rtl/mpmd_pkg.sv =====
package mpmd_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 24;
	localparam int OUT_W           = 33;
	localparam int RC_W            = 7;
	localparam logic [RC_W-1:0] RC_RESET = 7'd60;
	localparam int CHUNK_W         = 16;
	localparam int DIV_W           = 16;

	typedef struct packed {
		logic [DIV_W-1:0] q;
		logic [1:0]       r;
	} div3_t;

	// 16 bits of a long division by three, two bits per digit
	function automatic div3_t div3_chunk(input logic [1:0] rem, input logic [DIV_W-1:0] x);
		div3_t      res;
		logic [3:0] cur;
		logic [1:0] r;
		logic [1:0] qd;
		r = rem;
		res.q = '0;
		for (int i = DIV_W / 2 - 1; i >= 0; i--) begin
			cur = {r, x[2*i +: 2]};
			if (cur >= 4'd9) begin
				qd = 2'd3;
				r  = 2'(cur - 4'd9);
			end else if (cur >= 4'd6) begin
				qd = 2'd2;
				r  = 2'(cur - 4'd6);
			end else if (cur >= 4'd3) begin
				qd = 2'd1;
				r  = 2'(cur - 4'd3);
			end else begin
				qd = 2'd0;
				r  = 2'(cur);
			end
			res.q[2*i +: 2] = qd;
		end
		res.r = r;
		return res;
	endfunction

endpackage

// ===== rtl/mpmd_if.sv =====
interface mpmd_in_if
	import mpmd_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] a_start_x;
	logic signed [COORD_WIDTH-1:0] a_start_y;
	logic signed [COORD_WIDTH-1:0] a_end_x;
	logic signed [COORD_WIDTH-1:0] a_end_y;
	logic signed [COORD_WIDTH-1:0] b_start_x;
	logic signed [COORD_WIDTH-1:0] b_start_y;
	logic signed [COORD_WIDTH-1:0] b_end_x;
	logic signed [COORD_WIDTH-1:0] b_end_y;

	modport source (
		output valid, a_start_x, a_start_y, a_end_x, a_end_y,
		       b_start_x, b_start_y, b_end_x, b_end_y,
		input  ready
	);
	modport sink (
		input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
		       b_start_x, b_start_y, b_end_x, b_end_y,
		output ready
	);
endinterface

interface mpmd_out_if
	import mpmd_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] min_distance;

	modport source (output valid, min_distance, input ready);
	modport sink (input valid, min_distance, output ready);
endinterface

// ===== rtl/mpmd_third.sv =====
module mpmd_third
	import mpmd_pkg::*;
#(
	parameter int P_W = 40
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [P_W-1:0] s_i,
	input  logic signed [P_W-1:0] e_i,
	output logic                  done,
	output logic signed [P_W-1:0] one_o,
	output logic signed [P_W-1:0] two_o
);
	localparam int NDIG = (P_W + DIV_W - 1) / DIV_W;
	localparam int MW   = NDIG * DIV_W;
	localparam int CW   = $clog2(NDIG + 1);

	logic [MW-1:0]       mag_q;
	logic [MW-1:0]       quot_q;
	logic [1:0]          rem_q;
	logic                neg_q;
	logic [CW-1:0]       cnt_q;
	logic                busy_q;
	logic                done_q;
	logic signed [P_W:0] d;
	logic [P_W-1:0]      mag;
	logic [P_W-1:0]      t;
	div3_t               stp;

	assign d   = {e_i[P_W-1], e_i} - {s_i[P_W-1], s_i};
	assign mag = d[P_W] ? P_W'(-d) : P_W'(d);
	assign stp = div3_chunk(rem_q, mag_q[MW-1 -: DIV_W]);
	assign t   = quot_q[P_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NDIG);
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q  <= MW'(mag);
			neg_q  <= d[P_W];
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				mag_q  <= mag_q << DIV_W;
				quot_q <= (quot_q << DIV_W) | MW'(stp.q);
				rem_q  <= stp.r;
			end else if (neg_q) begin
				one_o <= P_W'(s_i - $signed({1'b0, t}));
				two_o <= P_W'(e_i + $signed({1'b0, t}));
			end else begin
				one_o <= P_W'(s_i + $signed({1'b0, t}));
				two_o <= P_W'(e_i - $signed({1'b0, t}));
			end
		end
	end

	assign done = done_q;
endmodule

// ===== rtl/mpmd_mul_cell.sv =====
module mpmd_mul_cell
	import mpmd_pkg::*;
#(
	parameter int IDX   = 0,
	parameter int A_W   = 40,
	parameter int B_W   = 48,
	parameter int ACC_W = 80
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld_i,
	input  logic [A_W-1:0]   a_i,
	input  logic [B_W-1:0]   b_i,
	input  logic [ACC_W-1:0] acc_i,
	output logic             vld_o,
	output logic [A_W-1:0]   a_o,
	output logic [B_W-1:0]   b_o,
	output logic [ACC_W-1:0] acc_o
);
	logic [A_W+CHUNK_W-1:0] pp;

	assign pp = a_i * b_i[IDX*CHUNK_W +: CHUNK_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		a_o   <= a_i;
		b_o   <= b_i;
		acc_o <= acc_i + (ACC_W'(pp) << (IDX * CHUNK_W));
	end
endmodule

// ===== rtl/mpmd_sqrt.sv =====
module mpmd_sqrt
	import mpmd_pkg::*;
#(
	parameter int IN_W = 65,
	localparam int RW  = (IN_W + 1) / 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [IN_W-1:0] val,
	output logic            done,
	output logic [RW-1:0]   root
);
	localparam int CW = $clog2(RW + 1);

	logic [2*RW-1:0] v_q;
	logic [RW:0]     rem_q;
	logic [RW-1:0]   root_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [RW+2:0]   rem_n;
	logic [RW+2:0]   trial;

	assign rem_n = {rem_q, v_q[2*RW-1 -: 2]};
	assign trial = (RW+3)'({root_q, 2'b01});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= (2*RW)'(val);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q <= v_q << 2;
			if (rem_n >= trial) begin
				rem_q  <= (RW+1)'(rem_n - trial);
				root_q <= (root_q << 1) | RW'(1);
			end else begin
				rem_q  <= (RW+1)'(rem_n);
				root_q <= root_q << 1;
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

// ===== rtl/moving_points_min_distance.sv =====
// Sequential: one request at a time, the next is taken once the result sits in the output register.
// Each request runs a start-point pass, then round_count search rounds, then the square root
// and the output register. Each round: the divide-by-3 units (load, 3 digits, fix-up, handoff),
// the difference step, 4 feeds through the 3 cells of the squaring chain, and the compare step.
// Reset: round_count returns to 60, control and output valid clear; no clearing pass.
module moving_points_min_distance
	import mpmd_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  logic [RC_W-1:0] wr_data,
	mpmd_in_if.sink         item,
	mpmd_out_if.source      result
);
	localparam int P_W   = COORD_WIDTH + FRAC_BITS;
	localparam int NC    = (P_W + CHUNK_W - 1) / CHUNK_W;
	localparam int B_W   = NC * CHUNK_W;
	localparam int PR_W  = 2 * P_W;
	localparam int SQ_W  = PR_W + 1;
	localparam int SHIFT = 2 * FRAC_BITS - 32;
	localparam int RSH   = SHIFT > 0 ? SHIFT : 0;
	localparam int LSH   = SHIFT < 0 ? -SHIFT : 0;
	localparam int SH_W  = SQ_W + LSH;
	localparam int RW    = (SH_W + 1) / 2;
	localparam int MW    = RW > OUT_W ? RW : OUT_W;
	localparam int AX = 0, AY = 1, BX = 2, BY = 3;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_DIV  = 7'b0000010,
		S_DIFF = 7'b0000100,
		S_MUL  = 7'b0001000,
		S_CMP  = 7'b0010000,
		S_ROOT = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t                state_q;
	logic [RC_W-1:0]       rc_q;
	logic [RC_W-1:0]       rnd_q;
	logic                  init_q;
	logic                  th_go_q;
	logic [2:0]            feed_q;
	logic [1:0]            col_q;
	logic signed [P_W-1:0] s_q [4];
	logic signed [P_W-1:0] e_q [4];
	logic signed [P_W-1:0] th_one [4];
	logic signed [P_W-1:0] th_two [4];
	logic [3:0]            th_done;
	logic [P_W-1:0]        dif_q [4];
	logic [SQ_W-1:0]       acc1_q;
	logic [SQ_W-1:0]       acc2_q;
	logic                  res_v_q;
	logic [OUT_W-1:0]      res_d_q;
	logic                  finish;
	logic                  sq_start;
	logic [SH_W-1:0]       sq_val;
	logic                  sq_done;
	logic [RW-1:0]         sq_root;
	logic [MW-1:0]         root_ext;
	logic [OUT_W-1:0]      dist_sat;
	logic                  ch_v   [NC+1];
	logic [P_W-1:0]        ch_a   [NC+1];
	logic [B_W-1:0]        ch_b   [NC+1];
	logic [PR_W-1:0]       ch_acc [NC+1];

	function automatic logic signed [P_W-1:0] to_fix(input logic signed [COORD_WIDTH-1:0] c);
		logic signed [P_W-1:0] w;
		w = P_W'(c);
		return w <<< FRAC_BITS;
	endfunction

	function automatic logic [P_W-1:0] absd(input logic signed [P_W-1:0] a,
		input logic signed [P_W-1:0] b);
		logic signed [P_W:0] d;
		d = {a[P_W-1], a} - {b[P_W-1], b};
		return d[P_W] ? P_W'(-d) : P_W'(d);
	endfunction

	assign item.ready = (state_q == S_IDLE);

	for (genvar g = 0; g < 4; g++) begin : g_third
		mpmd_third #(.P_W(P_W)) u_third (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (th_go_q),
			.s_i    (s_q[g]),
			.e_i    (e_q[g]),
			.done   (th_done[g]),
			.one_o  (th_one[g]),
			.two_o  (th_two[g])
		);
	end

	assign ch_v[0]   = (state_q == S_MUL) && !feed_q[2];
	assign ch_a[0]   = dif_q[feed_q[1:0]];
	assign ch_b[0]   = B_W'(ch_a[0]);
	assign ch_acc[0] = '0;

	for (genvar g = 0; g < NC; g++) begin : g_cell
		mpmd_mul_cell #(.IDX(g), .A_W(P_W), .B_W(B_W), .ACC_W(PR_W)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (ch_v[g]),
			.a_i    (ch_a[g]),
			.b_i    (ch_b[g]),
			.acc_i  (ch_acc[g]),
			.vld_o  (ch_v[g+1]),
			.a_o    (ch_a[g+1]),
			.b_o    (ch_b[g+1]),
			.acc_o  (ch_acc[g+1])
		);
	end

	assign finish   = init_q ? (rc_q == '0) : (RC_W'(rnd_q + 1'b1) == rc_q);
	assign sq_start = (state_q == S_CMP) && finish;
	assign sq_val   = (SH_W'(acc1_q) >> RSH) << LSH;

	mpmd_sqrt #(.IN_W(SH_W)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.val    (sq_val),
		.done   (sq_done),
		.root   (sq_root)
	);

	assign root_ext = MW'(sq_root);
	assign dist_sat = (root_ext > MW'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : OUT_W'(root_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rc_q    <= RC_RESET;
			rnd_q   <= '0;
			init_q  <= 1'b0;
			th_go_q <= 1'b0;
			feed_q  <= '0;
			col_q   <= '0;
			res_v_q <= 1'b0;
		end else begin
			th_go_q <= (state_q == S_CMP) && !finish;
			if (wr_en) begin
				rc_q <= wr_data;
			end
			if (state_q == S_OUT && (!res_v_q || result.ready)) begin
				res_v_q <= 1'b1;
			end else if (result.ready) begin
				res_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						init_q  <= 1'b1;
						rnd_q   <= '0;
						state_q <= S_DIFF;
					end
				end
				S_DIV: begin
					if (&th_done) begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					feed_q  <= '0;
					col_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (!feed_q[2]) begin
						feed_q <= feed_q + 1'b1;
					end
					if (ch_v[NC]) begin
						col_q <= col_q + 1'b1;
						if (col_q == 2'd3) begin
							state_q <= S_CMP;
						end
					end
				end
				S_CMP: begin
					init_q <= 1'b0;
					if (!init_q) begin
						rnd_q <= rnd_q + 1'b1;
					end
					if (finish) begin
						state_q <= S_ROOT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_ROOT: begin
					if (sq_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!res_v_q || result.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item.valid) begin
			s_q[AX] <= to_fix(item.a_start_x);
			s_q[AY] <= to_fix(item.a_start_y);
			e_q[AX] <= to_fix(item.a_end_x);
			e_q[AY] <= to_fix(item.a_end_y);
			s_q[BX] <= to_fix(item.b_start_x);
			s_q[BY] <= to_fix(item.b_start_y);
			e_q[BX] <= to_fix(item.b_end_x);
			e_q[BY] <= to_fix(item.b_end_y);
		end
		if (state_q == S_DIFF) begin
			if (init_q) begin
				dif_q[0] <= absd(s_q[AX], s_q[BX]);
				dif_q[1] <= absd(s_q[AY], s_q[BY]);
			end else begin
				dif_q[0] <= absd(th_one[AX], th_one[BX]);
				dif_q[1] <= absd(th_one[AY], th_one[BY]);
			end
			dif_q[2] <= absd(th_two[AX], th_two[BX]);
			dif_q[3] <= absd(th_two[AY], th_two[BY]);
		end
		if (state_q == S_MUL && ch_v[NC]) begin
			case (col_q)
				2'd0:    acc1_q <= SQ_W'(ch_acc[NC]);
				2'd1:    acc1_q <= acc1_q + SQ_W'(ch_acc[NC]);
				2'd2:    acc2_q <= SQ_W'(ch_acc[NC]);
				default: acc2_q <= acc2_q + SQ_W'(ch_acc[NC]);
			endcase
		end
		if (state_q == S_CMP && !init_q) begin
			for (int i = 0; i < 4; i++) begin
				if (acc1_q > acc2_q) begin
					s_q[i] <= th_one[i];
				end else begin
					e_q[i] <= th_two[i];
				end
			end
		end
		if (state_q == S_OUT && (!res_v_q || result.ready)) begin
			res_d_q <= dist_sat;
		end
	end

	assign result.valid        = res_v_q;
	assign result.min_distance = res_d_q;

	a_chain_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		ch_v[NC] |-> state_q == S_MUL)
		else $error("squaring chain result outside multiply phase");

	a_third_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		th_done[0] |-> state_q == S_DIV)
		else $error("third-point unit finished outside divide phase");

	a_root_in_root: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> state_q == S_ROOT)
		else $error("square root finished outside root phase");

	a_go_from_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		th_go_q |-> $past(state_q) == S_CMP)
		else $error("third-point start not issued by compare");
endmodule

// ===== tb/tb.sv =====
module tb;
	import mpmd_pkg::*;

	typedef struct {
		logic signed [15:0] a_start_x, a_start_y, a_end_x, a_end_y;
		logic signed [15:0] b_start_x, b_start_y, b_end_x, b_end_y;
	} segs_t;

	typedef struct {
		segs_t            segs;
		logic [RC_W-1:0]  rounds;
		bit               known;
		logic [OUT_W-1:0] exp_dist;
	} dir_row_t;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam logic [63:0] DIST_MAX = 64'h1_FFFF_FFFF;

	logic            clk;
	logic            arst_n;
	logic            wr_en;
	logic [RC_W-1:0] wr_data;

	mpmd_in_if  item_if();
	mpmd_out_if result_if();

	moving_points_min_distance u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.item    (item_if),
		.result  (result_if)
	);

	logic [OUT_W-1:0] expected_dist[$];
	logic [RC_W-1:0]  cur_rounds;
	int               fail_cnt = 0;
	int               burst_left;
	int               stall_mode = 0;
	int               stall_cnt = 0;
	dir_row_t         dir_rows[12];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic logic [127:0] dist_sq(input logic signed [63:0] px, py, qx, qy);
		logic signed [63:0] dx, dy;
		logic [63:0]        ux, uy;
		dx = px - qx;
		dy = py - qy;
		ux = (dx < 0) ? -dx : dx;
		uy = (dy < 0) ? -dy : dy;
		return 128'(ux) * 128'(ux) + 128'(uy) * 128'(uy);
	endfunction

	function automatic void split_thirds(input logic signed [63:0] s, e,
			output logic signed [63:0] one, two);
		logic signed [63:0] t;
		t = ((e >= s) ? e - s : s - e) / 3;
		if (e >= s) begin
			one = s + t;
			two = e - t;
		end else begin
			one = s - t;
			two = e + t;
		end
	endfunction

	function automatic logic [OUT_W-1:0] closest_approach(input segs_t c,
			input logic [RC_W-1:0] rounds);
		logic signed [63:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
		logic signed [63:0] fx0, fx1, fy0, fy1, sx0, sx1, sy0, sy1;
		logic [127:0]       near_sq, far_sq, v;
		logic [63:0]        root, cand;
		ax0 = c.a_start_x; ay0 = c.a_start_y; ax1 = c.a_end_x; ay1 = c.a_end_y;
		bx0 = c.b_start_x; by0 = c.b_start_y; bx1 = c.b_end_x; by1 = c.b_end_y;
		ax0 = ax0 <<< FRAC; ay0 = ay0 <<< FRAC; ax1 = ax1 <<< FRAC; ay1 = ay1 <<< FRAC;
		bx0 = bx0 <<< FRAC; by0 = by0 <<< FRAC; bx1 = bx1 <<< FRAC; by1 = by1 <<< FRAC;
		near_sq = dist_sq(ax0, ay0, bx0, by0);
		for (int r = 0; r < rounds; r++) begin
			split_thirds(ax0, ax1, fx0, fx1);
			split_thirds(ay0, ay1, fy0, fy1);
			split_thirds(bx0, bx1, sx0, sx1);
			split_thirds(by0, by1, sy0, sy1);
			near_sq = dist_sq(fx0, fy0, sx0, sy0);
			far_sq  = dist_sq(fx1, fy1, sx1, sy1);
			if (near_sq > far_sq) begin
				ax0 = fx0; ay0 = fy0; bx0 = sx0; by0 = sy0;
			end else begin
				ax1 = fx1; ay1 = fy1; bx1 = sx1; by1 = sy1;
			end
		end
		v = near_sq >> (2 * FRAC - 32);
		root = '0;
		for (int b = 63; b >= 0; b--) begin
			cand = root | (64'd1 << b);
			if (128'(cand) * 128'(cand) <= v)
				root = cand;
		end
		if (root > DIST_MAX)
			root = DIST_MAX;
		return root[OUT_W-1:0];
	endfunction

	function automatic segs_t mk_segs(input int ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
		segs_t s;
		s.a_start_x = 16'(ax0); s.a_start_y = 16'(ay0);
		s.a_end_x   = 16'(ax1); s.a_end_y   = 16'(ay1);
		s.b_start_x = 16'(bx0); s.b_start_y = 16'(by0);
		s.b_end_x   = 16'(bx1); s.b_end_y   = 16'(by1);
		return s;
	endfunction

	task automatic send_request(input segs_t s, input bit known, input logic [OUT_W-1:0] exp_d);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				item_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		item_if.valid     <= 1'b1;
		item_if.a_start_x <= s.a_start_x;
		item_if.a_start_y <= s.a_start_y;
		item_if.a_end_x   <= s.a_end_x;
		item_if.a_end_y   <= s.a_end_y;
		item_if.b_start_x <= s.b_start_x;
		item_if.b_start_y <= s.b_start_y;
		item_if.b_end_x   <= s.b_end_x;
		item_if.b_end_y   <= s.b_end_y;
		do @(posedge clk); while (!item_if.ready);
		expected_dist.push_back(known ? exp_d : closest_approach(s, cur_rounds));
	endtask

	task automatic drain_results();
		item_if.valid <= 1'b0;
		while (expected_dist.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_round_count(input logic [RC_W-1:0] v);
		drain_results();
		@(posedge clk);
		wr_en   <= 1'b1;
		wr_data <= v;
		@(posedge clk);
		wr_en      <= 1'b0;
		cur_rounds  = v;
	endtask

	function automatic segs_t rand_segs();
		int kind, cx, cy, dx, dy, ox, oy;
		segs_t s;
		kind = $urandom_range(0, 9);
		cx = $signed(16'($urandom_range(0, 65535)));
		cy = $signed(16'($urandom_range(0, 65535)));
		if (kind <= 3) begin
			s = mk_segs($urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom);
		end else if (kind <= 6) begin
			s = mk_segs(cx + $urandom_range(0, 200) - 100, cy + $urandom_range(0, 200) - 100,
				cx + $urandom_range(0, 200) - 100, cy + $urandom_range(0, 200) - 100,
				cx + $urandom_range(0, 200) - 100, cy + $urandom_range(0, 200) - 100,
				cx + $urandom_range(0, 200) - 100, cy + $urandom_range(0, 200) - 100);
		end else if (kind == 7) begin
			dx = $urandom_range(0, 2000) - 1000;
			dy = $urandom_range(0, 2000) - 1000;
			ox = $urandom_range(0, 60) - 30;
			oy = $urandom_range(0, 60) - 30;
			s = mk_segs(cx, cy, cx + dx, cy + dy, cx + ox, cy + oy, cx + ox + dx, cy + oy + dy);
		end else if (kind == 8) begin
			dx = $urandom_range(0, 2000) - 1000;
			dy = $urandom_range(0, 2000) - 1000;
			s = mk_segs(cx, cy, cx + dx, cy + dy, cx + dx, cy + dy, cx, cy);
		end else begin
			s = mk_segs(cx, cy, cx, cy, $urandom, $urandom, $urandom, $urandom);
		end
		return s;
	endfunction

	always @(posedge clk) begin
		if (result_if.valid && result_if.ready) begin
			if (expected_dist.size() == 0) begin
				$error("unexpected result min_distance=%0d", result_if.min_distance);
				fail_cnt++;
			end else begin
				if (result_if.min_distance !== expected_dist[0]) begin
					$error("min_distance expected %0d actual %0d",
						expected_dist[0], result_if.min_distance);
					fail_cnt++;
				end
				void'(expected_dist.pop_front());
			end
		end
		if (stall_cnt == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_cnt  = $urandom_range(50, 400);
		end
		stall_cnt--;
		case (stall_mode)
			0: result_if.ready <= 1'b1;
			1: result_if.ready <= ($urandom_range(0, 3) != 0);
			2: result_if.ready <= ($urandom_range(0, 3) == 0);
			default: result_if.ready <= (stall_cnt % 7 < 3);
		endcase
	end

	initial begin
		logic [RC_W-1:0] rc;
		burst_left = 0;
		cur_rounds = RC_RESET;
		arst_n            <= 1'b0;
		wr_en             <= 1'b0;
		wr_data           <= '0;
		item_if.valid     <= 1'b0;
		item_if.a_start_x <= '0;
		item_if.a_start_y <= '0;
		item_if.a_end_x   <= '0;
		item_if.a_end_y   <= '0;
		item_if.b_start_x <= '0;
		item_if.b_start_y <= '0;
		item_if.b_end_x   <= '0;
		item_if.b_end_y   <= '0;

		dir_rows[0]  = '{mk_segs(0, 0, 0, 0, 0, 0, 0, 0), 7'd60, 1, 33'd0};
		dir_rows[1]  = '{mk_segs(0, 0, 100, 0, 0, 3, 100, 3), 7'd60, 1, 33'd196608};
		dir_rows[2]  = '{mk_segs(0, 0, 500, -20, 3, 4, -7, 90), 7'd0, 1, 33'd327680};
		dir_rows[3]  = '{mk_segs(-32768, -32768, 0, 0, 32767, 32767, 1, 1), 7'd0, 0, '0};
		dir_rows[4]  = '{mk_segs(9, -9, 30, 30, 9, -9, -30, 30), 7'd0, 1, 33'd0};
		dir_rows[5]  = '{mk_segs(-100, 0, 100, 0, 0, -100, 0, 100), 7'd1, 0, '0};
		dir_rows[6]  = '{mk_segs(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768),
			7'd64, 0, '0};
		dir_rows[7]  = '{mk_segs(-500, 700, 1200, -3, -500, 700, 1200, -3), 7'd64, 1, 33'd0};
		dir_rows[8]  = '{mk_segs(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767),
			7'd64, 1, 33'd0};
		dir_rows[9]  = '{mk_segs(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767),
			7'd127, 0, '0};
		dir_rows[10] = '{mk_segs(-1, -1, -32768, -32768, 1, 1, 32767, 32767), 7'd127, 0, '0};
		dir_rows[11] = '{mk_segs(5, 5, 5, 5, 8, 9, 8, 9), 7'd127, 1, 33'd327680};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].rounds != cur_rounds)
				write_round_count(dir_rows[i].rounds);
			send_request(dir_rows[i].segs, dir_rows[i].known, dir_rows[i].exp_dist);
		end

		for (int p = 0; p < 13; p++) begin
			case (p)
				0: rc = 7'd1;
				1: rc = 7'd64;
				2: rc = 7'd2;
				default: rc = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(21, 64))
					: 7'($urandom_range(1, 20));
			endcase
			write_round_count(rc);
			for (int n = 0; n < 100; n++) begin
				// let the block run dry once with no request pending
				if (p == 5 && n == 50)
					drain_results();
				send_request(rand_segs(), 0, '0);
			end
		end

		drain_results();
		repeat (2000) @(posedge clk);
		if (fail_cnt == 0 && expected_dist.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
